>>> rtl/pal_pkg.sv
`timescale 1ns / 1ps

package pal_pkg;

   // field widths of a request and a result
   localparam int CMD_W      = 3;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 8;
   localparam int FIDX_W     = 8;
   localparam int LEN_W      = 9;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } pal_req_type;

   typedef struct packed {
      logic              status;
      logic              found;
      logic [FIDX_W-1:0] found_index;
      logic [LEN_W-1:0]  length;
      logic              is_empty;
      logic              is_full;
   } pal_res_type;

endpackage

>>> rtl/pal_mem.sv
`timescale 1ns / 1ps

// one write port, one read port, read data registered
module pal_mem #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 8
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [AW-1:0]         waddr,
   input  logic [DATA_WIDTH-1:0] wdata,
   input  logic                  re,
   input  logic [AW-1:0]         raddr,
   output logic [DATA_WIDTH-1:0] rdata
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/pal_seq.sv
`timescale 1ns / 1ps

module pal_seq
   import pal_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pal_req_type req,
   output logic        res_valid,
   input  logic        res_ready,
   output pal_res_type res
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SHIFT = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_PUT   = 5'b01000,
      ST_DONE  = 5'b10000
   } pal_state_type;

   pal_state_type         state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CMD_W-1:0]      op_ff, op_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         left_ff, left_in;
   logic                  rv_ff, rv_in;
   logic [AW-1:0]         dst_ff, dst_in;
   logic                  status_ff, status_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         fidx_ff, fidx_in;

   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

   logic [XW-1:0]         pos_x, cnt_x;
   logic                  full;

   assign pos_x = XW'(req.position);
   assign cnt_x = XW'(count_ff);
   assign full  = (count_ff == CW'(DEPTH));

   pal_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      word_in   = word_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      left_in   = left_ff;
      rv_in     = 1'b0;
      dst_in    = dst_ff;
      status_in = status_ff;
      found_in  = found_ff;
      fidx_in   = fidx_ff;
      mem_we    = 1'b0;
      mem_waddr = dst_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = idx_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req.cmd;
               word_in   = DATA_WIDTH'($unsigned(req.value));
               pos_in    = AW'(pos_x);
               status_in = 1'b0;
               found_in  = 1'b0;
               fidx_in   = '0;
               state_in  = ST_DONE;
               case (req.cmd)
                  CMD_INSERT: begin
                     if (!full && pos_x <= cnt_x) begin
                        // shift entries pos..count-1 up by one, top first
                        left_in  = CW'(cnt_x - pos_x);
                        idx_in   = AW'(cnt_x - XW'(1));
                        state_in = ST_SHIFT;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_x < cnt_x) begin
                        // shift entries pos+1..count-1 down by one, bottom first
                        left_in  = CW'(cnt_x - pos_x - XW'(1));
                        idx_in   = AW'(pos_x + XW'(1));
                        state_in = ST_SHIFT;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  CMD_CHANGE: begin
                     if (pos_x < cnt_x) begin
                        state_in = ST_PUT;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     left_in  = count_ff;
                     idx_in   = '0;
                     state_in = ST_SCAN;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     status_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // read one entry per cycle, write it back one slot over in the following cycle
            mem_we = rv_ff;
            if (left_ff != '0) begin
               mem_re  = 1'b1;
               rv_in   = 1'b1;
               left_in = left_ff - CW'(1);
               if (op_ff == CMD_DELETE) begin
                  idx_in = idx_ff + AW'(1);
                  dst_in = idx_ff - AW'(1);
               end else begin
                  idx_in = idx_ff - AW'(1);
                  dst_in = idx_ff + AW'(1);
               end
            end else if (!rv_ff) begin
               if (op_ff == CMD_DELETE) begin
                  count_in = count_ff - CW'(1);
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PUT;
               end
            end
         end

         ST_SCAN: begin
            if (left_ff != '0) begin
               mem_re  = 1'b1;
               rv_in   = 1'b1;
               left_in = left_ff - CW'(1);
               idx_in  = idx_ff + AW'(1);
               dst_in  = idx_ff;
            end
            if (rv_ff && mem_rdata == word_ff) begin
               found_in = 1'b1;
               fidx_in  = dst_ff;
               rv_in    = 1'b0;
               state_in = ST_DONE;
            end else if (left_ff == '0 && !rv_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = word_ff;
            if (op_ff == CMD_INSERT) begin
               count_in = count_ff + CW'(1);
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      word_ff   <= word_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      dst_ff    <= dst_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fidx_ff   <= fidx_in;
   end

   always_comb begin
      res.status      = status_ff;
      res.found       = found_ff;
      res.found_index = FIDX_W'(fidx_ff);
      res.length      = LEN_W'(count_ff);
      res.is_empty    = (count_ff == '0);
      res.is_full     = full;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write to one entry in one cycle");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SHIFT || state_ff == ST_PUT))
      else $error("memory write outside shift or put");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req.cmd == CMD_CLEAR) |=> (count_ff == '0))
      else $error("clear left entries behind");
`endif

endmodule

>>> rtl/positional_array_list_top.sv
`timescale 1ns / 1ps
// Insert shifts the entries from its position up by one, then writes the value; delete
// shifts the entries above its position down by one; change writes in place; search reads
// from index 0 until a hit or the end; clear empties the list; other codes set status.
// One command at a time; moves and scans go one entry per cycle through the list
// memory's single read port.
// Reset: synchronous, active high; empties the list (count zero), no memory sweep.
module positional_array_list_top
   import pal_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // command transfer
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] cmd, [34:3] value, [42:35] position, [47:43] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result transfer
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] status, [1] found, [9:2] found_index, [18:10] length,
   // [19] is_empty, [20] is_full, [23:21] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   pal_req_type req;
   pal_res_type res;
   logic        res_valid;
   logic        res_ready;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // unpack the command word
   always_comb begin
      req.cmd      = req_tdata[CMD_W-1:0];
      req.value    = req_tdata[CMD_W+VALUE_W-1:CMD_W];
      req.position = req_tdata[CMD_W+VALUE_W+POS_W-1:CMD_W+VALUE_W];
   end

   pal_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register: a finished result is parked here so the sequencer
   // can return to idle and take the next command while it waits
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      if (res_ready) begin
         rsp_tvalid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = {3'b000, res.is_full, res.is_empty, res.length,
                           res.found_index, res.found, res.status};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/sv/array_list_checker.sv
`timescale 1ns / 1ps

module array_list_checker
   import pal_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [LEN_W-1:0]      list_len,
   output int                    pending,
   output int                    error_count
);

   localparam int VALUE_LSB = CMD_W;
   localparam int POS_LSB   = CMD_W + VALUE_W;

   logic [VALUE_W-1:0] slots [DEPTH];
   logic [LEN_W-1:0]   list_count = '0;
   pal_res_type        expected_results [$];

   assign list_len = list_count;

   // applies one command to the shadow list and returns the result it should give
   function automatic pal_res_type apply_list_cmd(logic [CMD_W-1:0]   cmd,
                                                  logic [VALUE_W-1:0] value,
                                                  logic [POS_W-1:0]   pos);
      pal_res_type res;
      int          i;
      res = '0;
      case (cmd)
         CMD_INSERT: begin
            if (list_count >= DEPTH || pos > list_count) begin
               res.status = 1'b1;
            end else begin
               for (i = int'(list_count); i > int'(pos); i--)
                  slots[i] = slots[i-1];
               slots[pos] = value;
               list_count++;
            end
         end
         CMD_DELETE: begin
            if (pos >= list_count) begin
               res.status = 1'b1;
            end else begin
               for (i = int'(pos); i + 1 < int'(list_count); i++)
                  slots[i] = slots[i+1];
               list_count--;
            end
         end
         CMD_CHANGE: begin
            if (pos >= list_count)
               res.status = 1'b1;
            else
               slots[pos] = value;
         end
         CMD_SEARCH: begin
            // lowest matching index wins
            for (i = 0; i < int'(list_count); i++) begin
               if (!res.found && slots[i] == value) begin
                  res.found       = 1'b1;
                  res.found_index = FIDX_W'(i);
               end
            end
         end
         CMD_CLEAR: list_count = '0;
         default: res.status = 1'b1;
      endcase
      res.length   = list_count;
      res.is_empty = (list_count == 0);
      res.is_full  = (list_count == DEPTH);
      return res;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      pal_res_type want;
      if (reset) begin
         list_count = '0;
         expected_results.delete();
      end else begin
         // a result leaving at this edge always belongs to an older command
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no command outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_tdata[0]);
               check_field("found", want.found, rsp_tdata[1]);
               check_field("found_index", want.found_index, rsp_tdata[9:2]);
               check_field("length", want.length, rsp_tdata[18:10]);
               check_field("is_empty", want.is_empty, rsp_tdata[19]);
               check_field("is_full", want.is_full, rsp_tdata[20]);
               check_field("padding", 0, rsp_tdata[23:21]);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_list_cmd(req_tdata[CMD_W-1:0],
                                                      req_tdata[VALUE_LSB +: VALUE_W],
                                                      req_tdata[POS_LSB +: POS_W]));
      end
      pending = expected_results.size();
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pal_pkg::*;

   localparam int DEPTH = 256;

   // the block answers these codes with status set and leaves the list alone
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // live view of the shadow list, used to aim positions at the valid range
   logic [LEN_W-1:0]      list_len;
   int                    pending;
   int                    error_count;

   // set for a phase in which the bench adds no sender gaps and no result stalls
   bit                    no_idle;

   // small set of words so searches hit and duplicates pile up
   logic [VALUE_W-1:0]    word_pool [16];

   positional_array_list_top #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (VALUE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   array_list_checker #(
      .DEPTH (DEPTH)
   ) list_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .list_len    (list_len),
      .pending     (pending),
      .error_count (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. Slowest legal run: ~1850 commands, each with up to a full shift or scan plus
   // the longest sender gap plus the longest result stall, about 7 ms. Four times that and
   // then some.
   initial begin
      #30_000_000;
      $display("FAIL");
      $finish;
   end

   // Result side: ready held for random stretches, mostly high, short drops,
   // now and then a long stall. Changes only at the falling edge.
   initial begin : result_sink
      int hold;
      int pick;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            rsp_tready <= 1'b1;
         end else if (hold == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rsp_tready <= 1'b1;
               hold = $urandom_range(0, 7);
            end else if (pick < 95) begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(20, 60);
            end
         end else begin
            hold--;
         end
      end
   end

   // One command transfer. Called at a falling edge, returns at the falling
   // edge after the transfer with tvalid still high, so back-to-back commands
   // never drop tvalid within one time step.
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                           logic [POS_W-1:0] pos);
      int gap;
      int pick;
      gap = 0;
      if (!no_idle) begin
         pick = $urandom_range(0, 99);
         if (pick >= 95)
            gap = $urandom_range(15, 50);
         else if (pick >= 60)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // fields from bit 0 up: cmd, value, position; upper bits zero
      req_tdata  <= REQ_DATA_W'({pos, value, cmd});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop tvalid and hold off until every outstanding result has come back.
   // Always waits for at least the next falling edge, so a following send_cmd never
   // raises tvalid in the step where it was lowered.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // A run of random commands; weights are percentages per operation and
   // whatever is left over goes to unused codes.
   task automatic run_phase(int count, int w_ins, int w_del, int w_chg, int w_srch,
                            int w_clr);
      int                 k;
      int                 pick;
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < w_ins)
            cmd = CMD_INSERT;
         else if (pick < w_ins + w_del)
            cmd = CMD_DELETE;
         else if (pick < w_ins + w_del + w_chg)
            cmd = CMD_CHANGE;
         else if (pick < w_ins + w_del + w_chg + w_srch)
            cmd = CMD_SEARCH;
         else if (pick < w_ins + w_del + w_chg + w_srch + w_clr)
            cmd = CMD_CLEAR;
         else
            cmd = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));

         if ($urandom_range(0, 9) < 7)
            value = word_pool[$urandom_range(0, 15)];
         else
            value = $urandom();

         // mostly in range so the list really moves; some anywhere at all
         if ($urandom_range(0, 99) < 15)
            pos = POS_W'($urandom_range(0, 255));
         else if (cmd == CMD_INSERT)
            pos = (list_len > 255) ? POS_W'(255) : POS_W'($urandom_range(0, list_len));
         else if (list_len == 0)
            pos = '0;
         else
            pos = POS_W'($urandom_range(0, list_len - 1));

         send_cmd(cmd, value, pos);
      end
   endtask

   initial begin : stimulus
      int i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      no_idle    = 1'b0;

      word_pool[0] = 32'h8000_0000;
      word_pool[1] = 32'h7FFF_FFFF;
      word_pool[2] = 32'h0000_0000;
      word_pool[3] = 32'hFFFF_FFFF;
      for (i = 4; i < 16; i++)
         word_pool[i] = $urandom();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      // empty list: search finds nothing, delete/change/insert past end refused
      send_cmd(CMD_SEARCH, 32'h0000_0000, 8'd0);
      send_cmd(CMD_DELETE, 32'h0000_0000, 8'd0);
      send_cmd(CMD_CHANGE, 32'h1234_5678, 8'd0);
      send_cmd(CMD_INSERT, 32'h1234_5678, 8'd1);
      // build [-1, 0, MIN, MAX]: insert at head, append, insert in the middle
      send_cmd(CMD_INSERT, 32'h8000_0000, 8'd0);
      send_cmd(CMD_INSERT, 32'h7FFF_FFFF, 8'd1);
      send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 8'd0);
      send_cmd(CMD_INSERT, 32'h0000_0000, 8'd1);
      send_cmd(CMD_INSERT, 32'h5555_AAAA, 8'd5);
      send_cmd(CMD_SEARCH, 32'h7FFF_FFFF, 8'd0);
      // duplicate of the head value: search must report the lower index
      send_cmd(CMD_CHANGE, 32'hFFFF_FFFF, 8'd2);
      send_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 8'd0);
      send_cmd(CMD_CHANGE, 32'hAAAA_5555, 8'd4);
      // delete the last entry, then at the length, then the head
      send_cmd(CMD_DELETE, 32'h0000_0000, 8'd3);
      send_cmd(CMD_DELETE, 32'h0000_0000, 8'd3);
      send_cmd(CMD_DELETE, 32'hFFFF_FFFF, 8'd0);
      send_cmd(CMD_SEARCH, 32'h7FFF_FFFF, 8'd0);
      send_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 8'd0);
      // unused codes, all high bits exercised
      send_cmd(CMD_UNUSED_LO, 32'hFFFF_FFFF, 8'd255);
      send_cmd(CMD_UNUSED_LO + 3'd1, 32'h0000_0000, 8'd0);
      send_cmd(CMD_UNUSED_HI, 32'h8000_0000, 8'd255);
      send_cmd(CMD_INSERT, 32'h7FFF_FFFF, 8'd255);
      send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 8'd255);
      send_cmd(CMD_SEARCH, 32'h0000_0000, 8'd0);
      drain_results();

      // --- random ---
      // fill: insert heavy, reaches full and keeps pushing against it
      run_phase(450, 85, 5, 5, 4, 0);
      drain_results();

      // mixed at full speed, no gaps on either side
      no_idle = 1'b1;
      run_phase(300, 35, 30, 15, 18, 1);
      drain_results();
      no_idle = 1'b0;

      // drain: delete heavy, runs the list down to empty and past it
      run_phase(350, 10, 70, 5, 14, 0);
      drain_results();

      // general mix with the odd clear
      run_phase(700, 40, 25, 12, 20, 2);

      // wait for the tail, then idle for longer than a full shift or scan to catch strays
      drain_results();
      repeat (DEPTH + 8) @(negedge clock);

      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
